// ===== design/kcop_pkg.sv =====
// Package for the keyed command object parser: item types, parse phases,
// matcher codes and the character tables of the incremental key and command matchers.
// Depends on nothing; every design file imports it.
package kcop_pkg;

	localparam int VALUE_CHARS_DEF = 7;
	localparam int TEXT_W = 56;

	typedef enum logic [0:0] {
		KIND_CHAR    = 1'b0,
		KIND_RESTART = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		PH_OPEN  = 3'd0,
		PH_KEYQ  = 3'd1,
		PH_KEY   = 3'd2,
		PH_COLON = 3'd3,
		PH_VALQ  = 3'd4,
		PH_VAL   = 3'd5,
		PH_AFTER = 3'd6,
		PH_DONE  = 3'd7
	} phase_t;

	typedef logic [4:0] match_t;

	localparam match_t M_START   = 5'd0;
	localparam match_t M_DEAD    = 5'd31;
	localparam match_t M_CMD_KEY = 5'd7;
	localparam match_t M_VAL_KEY = 5'd12;
	localparam match_t M_PIN     = 5'd7;
	localparam match_t M_DW      = 5'd19;
	localparam match_t M_BRANCH2 = 5'd8;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_PIN  = 2'd1;
	localparam logic [1:0] ACT_DW   = 2'd2;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} kcop_in_t;

	typedef struct packed {
		logic              accepted;
		logic              parse_error;
		logic              object_done;
		logic [1:0]        action;
		logic [TEXT_W-1:0] value_text;
		logic [2:0]        value_length;
		logic              value_truncated;
	} kcop_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
	endfunction

	// Expected character for each live key matcher state: "command" on 1..6
	// and "value" on 8..11.
	function automatic logic [7:0] key_char(input match_t m);
		logic [7:0] r;
		case (m)
			5'd1:    r = "o";
			5'd2:    r = "m";
			5'd3:    r = "m";
			5'd4:    r = "a";
			5'd5:    r = "n";
			5'd6:    r = "d";
			5'd8:    r = "a";
			5'd9:    r = "l";
			5'd10:   r = "u";
			5'd11:   r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic match_t key_next(input match_t m, input logic [7:0] c);
		match_t r;
		if (m == M_START) begin
			r = (c == "c") ? 5'd1 : ((c == "v") ? M_BRANCH2 : M_DEAD);
		end else if ((m >= 5'd1 && m <= 5'd6) || (m >= 5'd8 && m <= 5'd11)) begin
			r = (c == key_char(m)) ? m + 5'd1 : M_DEAD;
		end else begin
			r = M_DEAD;
		end
		return r;
	endfunction

	// Expected character for each live command matcher state: "pinMode" on
	// 1..6 and "digitalWrite" on 8..18.
	function automatic logic [7:0] cmd_char(input match_t m);
		logic [7:0] r;
		case (m)
			5'd1:    r = "i";
			5'd2:    r = "n";
			5'd3:    r = "M";
			5'd4:    r = "o";
			5'd5:    r = "d";
			5'd6:    r = "e";
			5'd8:    r = "i";
			5'd9:    r = "g";
			5'd10:   r = "i";
			5'd11:   r = "t";
			5'd12:   r = "a";
			5'd13:   r = "l";
			5'd14:   r = "W";
			5'd15:   r = "r";
			5'd16:   r = "i";
			5'd17:   r = "t";
			5'd18:   r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic match_t cmd_next(input match_t m, input logic [7:0] c);
		match_t r;
		if (m == M_START) begin
			r = (c == "p") ? 5'd1 : ((c == "d") ? M_BRANCH2 : M_DEAD);
		end else if ((m >= 5'd1 && m <= 5'd6) || (m >= 5'd8 && m <= 5'd18)) begin
			r = (c == cmd_char(m)) ? m + 5'd1 : M_DEAD;
		end else begin
			r = M_DEAD;
		end
		return r;
	endfunction

endpackage

// ===== design/keyed_command_object_parser.sv =====
// Keyed command object parser: a single module holding the parse state, the
// incremental matchers and the registered status output.
// Depends on kcop_pkg for item types, phase codes and matcher tables.
//
// Usage: characters of an object such as {"command":"pinMode","value":"13"}
// arrive one per item on the char channel (char_valid, char_stall,
// char_item). An item of kind restart clears the parse but keeps the saved
// action and value. Every item produces exactly one status item on the
// status channel (status_valid, status_stall, status_item) that reports
// whether the character was accepted, the sticky error flag, completion of
// the object, and the saved action and value text.
// The status output is registered: the status item for a character accepted at a
// clock edge is presented right after that edge. Throughput is one item per cycle
// while the receiver does not stall; the whole parse step is a single pass of logic
// from the state registers into the status register.
// While the receiver stalls, the status register holds its item and the
// char channel stalls only while that held item is still waiting.
// Reset clears the parse, the saved action (none) and the saved value, and
// leaves the status channel empty.
module keyed_command_object_parser import kcop_pkg::*; #(
	parameter int VALUE_CHARS = VALUE_CHARS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  kcop_in_t  char_item,
	output logic      status_valid,
	input  logic      status_stall,
	output kcop_out_t status_item
);

	localparam int TW = 8 * VALUE_CHARS;
	// Entry length saturates at VALUE_CHARS + 1, so it must hold that value.
	localparam int LW = $clog2(VALUE_CHARS + 2);
	localparam logic [LW-1:0] LEN_MAX = LW'(VALUE_CHARS);

	phase_t        phase_q, phase_n;
	match_t        key_q, key_n;
	match_t        cmd_q, cmd_n;
	logic [TW-1:0] entry_text_q, entry_text_n;
	logic [LW-1:0] entry_len_q, entry_len_n;
	logic [1:0]    action_q, action_n;
	logic [TW-1:0] saved_text_q, saved_text_n;
	logic [LW-1:0] saved_len_q, saved_len_n;
	logic          error_q, error_n;
	logic          status_valid_q;
	kcop_out_t     status_q, status_n;
	logic          take;
	logic          acc;
	logic          fail;
	logic [LW-1:0] len_clip;

	// The status register frees up when it is empty or being taken this cycle.
	assign char_stall = status_valid_q && status_stall;
	assign take       = char_valid && !char_stall;

	always_comb begin
		phase_n      = phase_q;
		key_n        = key_q;
		cmd_n        = cmd_q;
		entry_text_n = entry_text_q;
		entry_len_n  = entry_len_q;
		action_n     = action_q;
		saved_text_n = saved_text_q;
		saved_len_n  = saved_len_q;
		error_n      = error_q;
		acc          = 1'b1;
		fail         = 1'b0;

		if (char_item.kind == KIND_RESTART) begin
			phase_n      = PH_OPEN;
			key_n        = M_START;
			cmd_n        = M_START;
			entry_text_n = '0;
			entry_len_n  = '0;
			error_n      = 1'b0;
		end else if (phase_q == PH_DONE) begin
			// A finished object accepts and ignores everything until a restart.
			acc = 1'b1;
		end else if (error_q) begin
			acc = 1'b0;
		end else begin
			case (phase_q)
				PH_OPEN: begin
					if (char_item.ch == "{") begin
						phase_n = PH_KEYQ;
						key_n   = M_START;
					end else if (!is_space(char_item.ch)) begin
						fail = 1'b1;
					end
				end
				PH_KEYQ: begin
					if (char_item.ch == "\"") begin
						phase_n = PH_KEY;
						key_n   = M_START;
					end else if (!is_space(char_item.ch)) begin
						fail = 1'b1;
					end
				end
				PH_KEY: begin
					if (char_item.ch == "\"") begin
						phase_n = PH_COLON;
					end else begin
						key_n = key_next(key_q, char_item.ch);
					end
				end
				PH_COLON: begin
					if (char_item.ch == ":") begin
						phase_n = PH_VALQ;
					end else if (!is_space(char_item.ch)) begin
						fail = 1'b1;
					end
				end
				PH_VALQ: begin
					// An unknown key fails on the first character after its colon.
					if (key_q != M_CMD_KEY && key_q != M_VAL_KEY) begin
						fail = 1'b1;
					end else if (char_item.ch == "\"") begin
						phase_n      = PH_VAL;
						cmd_n        = M_START;
						entry_text_n = '0;
						entry_len_n  = '0;
					end else if (!is_space(char_item.ch)) begin
						fail = 1'b1;
					end
				end
				PH_VAL: begin
					if (char_item.ch == "\"") begin
						phase_n = PH_AFTER;
					end else begin
						cmd_n = cmd_next(cmd_q, char_item.ch);
						for (int i = 0; i < VALUE_CHARS; i++) begin
							if (entry_len_q == LW'(i)) begin
								entry_text_n[8*i +: 8] = char_item.ch;
							end
						end
						if (entry_len_q <= LEN_MAX) begin
							entry_len_n = entry_len_q + LW'(1);
						end
					end
				end
				PH_AFTER: begin
					// The finished entry is saved before the character is checked.
					if (key_q == M_CMD_KEY) begin
						if (cmd_q == M_PIN) begin
							action_n = ACT_PIN;
						end else if (cmd_q == M_DW) begin
							action_n = ACT_DW;
						end
					end else if (key_q == M_VAL_KEY) begin
						saved_text_n = entry_text_q;
						saved_len_n  = entry_len_q;
					end
					if (char_item.ch == "}") begin
						phase_n = PH_DONE;
					end else if (char_item.ch == ",") begin
						phase_n      = PH_KEYQ;
						key_n        = M_START;
						cmd_n        = M_START;
						entry_text_n = '0;
						entry_len_n  = '0;
					end else if (!is_space(char_item.ch)) begin
						fail = 1'b1;
					end
				end
				default: begin
					fail = 1'b1;
				end
			endcase
			if (fail) begin
				error_n = 1'b1;
				acc     = 1'b0;
			end
		end

		len_clip = (saved_len_n > LEN_MAX) ? LEN_MAX : saved_len_n;

		status_n.accepted        = acc;
		status_n.parse_error     = error_n;
		status_n.object_done     = (phase_n == PH_DONE);
		status_n.action          = action_n;
		status_n.value_text      = TEXT_W'(saved_text_n);
		status_n.value_length    = 3'(len_clip);
		status_n.value_truncated = (saved_len_n > LEN_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OPEN;
			key_q        <= M_START;
			cmd_q        <= M_START;
			entry_text_q <= '0;
			entry_len_q  <= '0;
			action_q     <= ACT_NONE;
			saved_text_q <= '0;
			saved_len_q  <= '0;
			error_q      <= 1'b0;
		end else if (take) begin
			phase_q      <= phase_n;
			key_q        <= key_n;
			cmd_q        <= cmd_n;
			entry_text_q <= entry_text_n;
			entry_len_q  <= entry_len_n;
			action_q     <= action_n;
			saved_text_q <= saved_text_n;
			saved_len_q  <= saved_len_n;
			error_q      <= error_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (take) begin
			status_valid_q <= 1'b1;
		end else if (!status_stall) begin
			status_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_n;
		end
	end

	assign status_valid = status_valid_q;
	assign status_item  = status_q;

endmodule

// ===== sim/keyed_command_object_parser_tb.sv =====
// Self-checking testbench for keyed_command_object_parser: directed and random character
// streams, random idling on both channels, checked item by item against a built-in predictor.
// Depends on kcop_pkg and the keyed_command_object_parser module.
`timescale 1ns / 100ps

module keyed_command_object_parser_tb;
	import kcop_pkg::*;

	localparam int VCH = VALUE_CHARS_DEF;

	// Characters with a role in the object syntax.
	localparam logic [7:0] CH_OPEN_BRACE  = 8'h7b;
	localparam logic [7:0] CH_CLOSE_BRACE = 8'h7d;
	localparam logic [7:0] CH_QUOTE       = 8'h22;
	localparam logic [7:0] CH_COLON       = 8'h3a;
	localparam logic [7:0] CH_COMMA       = 8'h2c;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_TAB         = 8'h09;
	localparam logic [7:0] CH_CR          = 8'h0d;
	localparam logic [7:0] CH_LF          = 8'h0a;

	// Keywords, first character in the most significant byte.
	localparam logic [8*7-1:0]  KW_COMMAND       = "command";
	localparam logic [8*5-1:0]  KW_VALUE         = "value";
	localparam logic [8*7-1:0]  KW_PIN_MODE      = "pinMode";
	localparam logic [8*12-1:0] KW_DIGITAL_WRITE = "digitalWrite";

	localparam int HOLD_AT     = 450;   // accepted chars before the long receiver hold-off
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before giving up

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_stall;
	kcop_in_t  char_item = '0;
	logic      status_valid;
	logic      status_stall = 1'b0;
	kcop_out_t status_item;

	keyed_command_object_parser #(
		.VALUE_CHARS(VCH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item(char_item),
		.status_valid(status_valid),
		.status_stall(status_stall),
		.status_item(status_item)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Items still to be offered, and the status items the parser owes us.
	kcop_in_t  char_backlog[$];
	kcop_out_t status_due[$];

	int   planned = 0;       // items queued so far
	int   chars_taken = 0;   // items accepted by the parser
	int   fails = 0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	int   idle_cycles = 0;
	bit   hold_done = 1'b0;
	bit   char_fired = 1'b0; // an item went in at the latest rising edge
	bit   calm = 1'b0;       // no idling on either side in the closing stretch
	bit   garble = 1'b0;     // sprinkle random bytes into the object being built
	logic [31:0] cycle_no = '0;

	// ------------------------------------------------------------------
	// Predictor: the parse state as the block should hold it.
	// ------------------------------------------------------------------
	phase_t      parse_ph = PH_OPEN;
	match_t      key_pos = M_START;    // progress through "command" / "value"
	match_t      cmd_pos = M_START;    // progress through "pinMode" / "digitalWrite"
	logic [55:0] field_buf = '0;       // text of the value being read
	logic [3:0]  field_cnt = '0;
	logic [1:0]  held_action = ACT_NONE;
	logic [55:0] held_text = '0;
	logic [3:0]  held_cnt = '0;
	logic        sticky_err = 1'b0;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// The key matcher walks "command" on 1..6 and "value" on 8..11; 7 and 12 mean a
	// full match, and any wrong character drops it into the dead state for good.
	function automatic match_t step_key(input match_t m, input logic [7:0] c);
		int k;
		k = int'(m);
		if (k == 0) begin
			if (c == KW_COMMAND[55:48])
				return match_t'(1);
			if (c == KW_VALUE[39:32])
				return M_BRANCH2;
			return M_DEAD;
		end
		if (k <= 6)
			return (c == KW_COMMAND[8*(6-k) +: 8]) ? match_t'(k + 1) : M_DEAD;
		if (k >= 8 && k <= 11)
			return (c == KW_VALUE[8*(11-k) +: 8]) ? match_t'(k + 1) : M_DEAD;
		return M_DEAD;
	endfunction

	// Same scheme for the command text: "pinMode" on 1..6, "digitalWrite" on 8..18.
	function automatic match_t step_cmd(input match_t m, input logic [7:0] c);
		int k;
		k = int'(m);
		if (k == 0) begin
			if (c == KW_PIN_MODE[55:48])
				return match_t'(1);
			if (c == KW_DIGITAL_WRITE[95:88])
				return M_BRANCH2;
			return M_DEAD;
		end
		if (k <= 6)
			return (c == KW_PIN_MODE[8*(6-k) +: 8]) ? match_t'(k + 1) : M_DEAD;
		if (k >= 8 && k <= 18)
			return (c == KW_DIGITAL_WRITE[8*(18-k) +: 8]) ? match_t'(k + 1) : M_DEAD;
		return M_DEAD;
	endfunction

	// One character against a parse that is neither finished nor in error.
	// Returns 0 when the character breaks the syntax.
	function automatic logic take_char(input logic [7:0] c);
		case (parse_ph)
			PH_OPEN: begin
				if (is_blank(c))
					return 1'b1;
				if (c == CH_OPEN_BRACE) begin
					parse_ph = PH_KEYQ;
					key_pos = M_START;
					return 1'b1;
				end
			end
			PH_KEYQ: begin
				// A closing brace here (empty object, trailing comma) is not allowed.
				if (is_blank(c))
					return 1'b1;
				if (c == CH_QUOTE) begin
					parse_ph = PH_KEY;
					key_pos = M_START;
					return 1'b1;
				end
			end
			PH_KEY: begin
				if (c == CH_QUOTE)
					parse_ph = PH_COLON;
				else
					key_pos = step_key(key_pos, c);
				return 1'b1;
			end
			PH_COLON: begin
				if (is_blank(c))
					return 1'b1;
				if (c == CH_COLON) begin
					parse_ph = PH_VALQ;
					return 1'b1;
				end
			end
			PH_VALQ: begin
				// An unknown key fails on the first character after its colon,
				// whitespace included.
				if (key_pos == M_CMD_KEY || key_pos == M_VAL_KEY) begin
					if (is_blank(c))
						return 1'b1;
					if (c == CH_QUOTE) begin
						parse_ph = PH_VAL;
						cmd_pos = M_START;
						field_buf = '0;
						field_cnt = '0;
						return 1'b1;
					end
				end
			end
			PH_VAL: begin
				if (c == CH_QUOTE) begin
					parse_ph = PH_AFTER;
					return 1'b1;
				end
				cmd_pos = step_cmd(cmd_pos, c);
				if (field_cnt < VCH)
					field_buf[8*field_cnt +: 8] = c;
				if (field_cnt <= VCH)
					field_cnt++;
				return 1'b1;
			end
			PH_AFTER: begin
				// The entry is committed on any character after the closing quote,
				// before that character itself is judged.
				if (key_pos == M_CMD_KEY) begin
					if (cmd_pos == M_PIN)
						held_action = ACT_PIN;
					else if (cmd_pos == M_DW)
						held_action = ACT_DW;
				end else if (key_pos == M_VAL_KEY) begin
					held_text = field_buf;
					held_cnt = field_cnt;
				end
				if (is_blank(c))
					return 1'b1;
				if (c == CH_CLOSE_BRACE) begin
					parse_ph = PH_DONE;
					return 1'b1;
				end
				if (c == CH_COMMA) begin
					parse_ph = PH_KEYQ;
					key_pos = M_START;
					cmd_pos = M_START;
					field_buf = '0;
					field_cnt = '0;
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Advances the predicted state by one item and returns the status item it should give.
	function automatic kcop_out_t next_status(input kcop_in_t it);
		kcop_out_t  r;
		logic       ok;
		logic [3:0] len;
		ok = 1'b1;
		if (it.kind == KIND_RESTART) begin
			// Restart drops the parse but keeps the saved action and value.
			parse_ph = PH_OPEN;
			key_pos = M_START;
			cmd_pos = M_START;
			field_buf = '0;
			field_cnt = '0;
			sticky_err = 1'b0;
		end else if (parse_ph != PH_DONE) begin
			// A finished object swallows everything; an error rejects everything.
			if (sticky_err) begin
				ok = 1'b0;
			end else begin
				ok = take_char(it.ch);
				if (!ok)
					sticky_err = 1'b1;
			end
		end
		len = (held_cnt > VCH) ? 4'(VCH) : held_cnt;
		r.accepted = ok;
		r.parse_error = sticky_err;
		r.object_done = (parse_ph == PH_DONE);
		r.action = held_action;
		r.value_text = held_text;
		r.value_length = len[2:0];
		r.value_truncated = (held_cnt > VCH);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders. They only append to the backlog.
	// ------------------------------------------------------------------
	task automatic push_ch(input logic [7:0] c);
		kcop_in_t it;
		it.kind = KIND_CHAR;
		it.ch = c;
		if (garble && $urandom_range(0, 39) == 0)
			it.ch = 8'($urandom_range(0, 255));
		char_backlog.push_back(it);
		planned++;
	endtask

	task automatic push_restart();
		kcop_in_t it;
		it.kind = KIND_RESTART;
		it.ch = 8'($urandom_range(0, 255));   // ignored by the block, but exercised
		char_backlog.push_back(it);
		planned++;
	endtask

	task automatic push_blanks();
		int n;
		int i;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: push_ch(CH_SPACE);
				1: push_ch(CH_TAB);
				2: push_ch(CH_CR);
				default: push_ch(CH_LF);
			endcase
		end
	endtask

	// Any byte but the quote, mostly printable.
	function automatic logic [7:0] value_byte();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) == 0)
				c = 8'($urandom_range(0, 255));
			else
				c = 8'($urandom_range(32, 126));
		end while (c == CH_QUOTE);
		return c;
	endfunction

	task automatic push_text(input int n);
		int i;
		for (i = 0; i < n; i++)
			push_ch(value_byte());
	endtask

	// Pushes a keyword; a near miss either cuts it short or flips the case of one letter.
	task automatic push_word(input logic [95:0] w, input int n, input bit near);
		int         cut;
		int         flip;
		int         i;
		logic [7:0] c;
		cut = n;
		flip = -1;
		if (near) begin
			if ($urandom_range(0, 1))
				cut = $urandom_range(1, n - 1);
			else
				flip = $urandom_range(0, n - 1);
		end
		for (i = 0; i < cut; i++) begin
			c = w[8*(n-1-i) +: 8];
			if (i == flip)
				c ^= 8'h20;
			push_ch(c);
		end
	endtask

	// Mostly well-formed objects with random content; a few are broken on purpose.
	task automatic push_object();
		int entries;
		int e;
		int pick;
		int sel;
		int i;
		garble = ($urandom_range(0, 4) == 0);
		push_blanks();
		push_ch(CH_OPEN_BRACE);
		pick = $urandom_range(0, 19);
		entries = (pick == 0) ? 0 : $urandom_range(1, 3);
		for (e = 0; e < entries; e++) begin
			if (e > 0)
				push_ch(CH_COMMA);
			if ($urandom_range(0, 29) == 0)
				push_restart();
			push_blanks();
			push_ch(CH_QUOTE);
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				push_word(KW_COMMAND, 7, 1'b0);
			end else if (sel < 8) begin
				push_word(KW_VALUE, 5, 1'b0);
			end else if (sel == 8) begin
				if ($urandom_range(0, 1))
					push_word(KW_COMMAND, 7, 1'b1);
				else
					push_word(KW_VALUE, 5, 1'b1);
			end else begin
				for (i = $urandom_range(1, 8); i > 0; i--)
					push_ch(8'($urandom_range(97, 122)));
			end
			push_ch(CH_QUOTE);
			push_blanks();
			push_ch(CH_COLON);
			push_blanks();
			push_ch(CH_QUOTE);
			if (sel < 4) begin
				case ($urandom_range(0, 7))
					0, 1, 2: push_word(KW_PIN_MODE, 7, 1'b0);
					3, 4, 5: push_word(KW_DIGITAL_WRITE, 12, 1'b0);
					6: begin
						if ($urandom_range(0, 1))
							push_word(KW_PIN_MODE, 7, 1'b1);
						else
							push_word(KW_DIGITAL_WRITE, 12, 1'b1);
					end
					default: push_text($urandom_range(0, 9));
				endcase
			end else if ($urandom_range(0, 4) == 0) begin
				push_text($urandom_range(VCH + 1, VCH + 5));
			end else begin
				push_text($urandom_range(0, VCH));
			end
			push_ch(CH_QUOTE);
			push_blanks();
		end
		// Trailing comma case.
		if (pick == 1) begin
			push_ch(CH_COMMA);
			push_blanks();
		end
		push_ch(CH_CLOSE_BRACE);
		if ($urandom_range(0, 4) == 0)
			push_text($urandom_range(1, 3));
		garble = 1'b0;
		if ($urandom_range(0, 9) != 0)
			push_restart();
	endtask

	// Holds the sender back until the parser owes nothing.
	task automatic drain();
		while (char_backlog.size() != 0 || status_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Char channel driver: new values at the falling edge, acceptance at the rising edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : char_accept
		char_fired = arst_n && char_valid && !char_stall;
		if (char_fired) begin
			// Predict before popping so the backlog and the due list are never
			// both empty while an item is in flight.
			status_due.push_back(next_status(char_item));
			void'(char_backlog.pop_front());
			chars_taken++;
		end
	end

	always @(negedge clk) begin : char_driver
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (!char_valid || char_fired) begin
			// Only move on once the offered item is gone; a stalled item stays put.
			if (send_gap > 0) begin
				send_gap--;
				char_valid <= 1'b0;
			end else if (char_backlog.size() == 0) begin
				char_valid <= 1'b0;
			end else if (!calm && cycle_no[8:6] != 3'd5 && $urandom_range(0, 9) == 0) begin
				// Drop valid for a random gap, except in the quiet windows.
				send_gap = $urandom_range(0, 5);
				char_valid <= 1'b0;
			end else begin
				char_valid <= 1'b1;
				char_item <= char_backlog[0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Status channel: random stall bursts, one long hold-off to back the parser up.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : status_receiver
		if (!hold_done && chars_taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			status_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			status_stall <= 1'b1;
		end else if (!calm && cycle_no[7:6] != 2'd2 && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			status_stall <= 1'b1;
		end else begin
			status_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : status_check
		kcop_out_t want;
		if (arst_n && status_valid && !status_stall) begin
			if (status_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected status item %h, expected none", $time,
					status_item);
			end else begin
				want = status_due.pop_front();
				check_field("accepted", 64'(want.accepted), 64'(status_item.accepted));
				check_field("parse_error", 64'(want.parse_error),
					64'(status_item.parse_error));
				check_field("object_done", 64'(want.object_done),
					64'(status_item.object_done));
				check_field("action", 64'(want.action), 64'(status_item.action));
				check_field("value_text", 64'(want.value_text),
					64'(status_item.value_text));
				check_field("value_length", 64'(want.value_length),
					64'(status_item.value_length));
				check_field("value_truncated", 64'(want.value_truncated),
					64'(status_item.value_truncated));
			end
		end
	end

	// Gives up when no item moves on either channel for too long.
	always @(posedge clk) begin : watchdog
		cycle_no <= cycle_no + 1;
		if ((char_valid && !char_stall) || (status_valid && !status_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("keyed_command_object_parser_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int chunk;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// A value of nine characters holding the byte extremes: saved on the space
		// after its closing quote, truncated to seven characters.
		push_ch(CH_OPEN_BRACE);
		push_ch(CH_QUOTE);
		push_word(KW_VALUE, 5, 1'b0);
		push_ch(CH_QUOTE);
		push_ch(CH_COLON);
		push_ch(CH_QUOTE);
		push_ch(8'h00);
		push_ch(8'hff);
		push_word("ABCDEFG", 7, 1'b0);
		push_ch(CH_QUOTE);
		push_ch(CH_SPACE);
		push_ch(CH_CLOSE_BRACE);
		// Ignored once the object is complete.
		push_ch(CH_COLON);
		push_restart();
		// An empty object is an error, and the error then rejects everything.
		push_ch(CH_OPEN_BRACE);
		push_ch(CH_CLOSE_BRACE);
		push_ch(CH_OPEN_BRACE);
		push_restart();
		drain();

		// Random objects in chunks, draining between them; no idling in the last one.
		for (chunk = 0; chunk < 4; chunk++) begin
			calm = (chunk == 3);
			while (planned < 350 + 240 * chunk) begin
				if ($urandom_range(0, 11) == 0) begin
					push_text($urandom_range(1, 5));
					push_restart();
				end else begin
					push_object();
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("keyed_command_object_parser_tb: PASS");
		else
			$display("keyed_command_object_parser_tb: FAIL");
		$finish;
	end

endmodule
